// File: hw/rtl/gppr_pkg.sv
// ----------------------------------------------------------------------------
// Game pad poll package
// Shared codes, constants, the report type and the button and hat remap
// functions for the game pad poll and report block.
// ----------------------------------------------------------------------------
package gppr_pkg;

    // Request codes on the input channel.
    typedef enum logic {
        OP_START = 1'b0,
        OP_RX    = 1'b1
    } t_op;

    // Result kinds on the output channel.
    typedef enum logic {
        KIND_SEND   = 1'b0,
        KIND_REPORT = 1'b1
    } t_kind;

    // Configuration register indexes.
    typedef enum logic {
        CFG_DEAD_LOW  = 1'b0,
        CFG_DEAD_HIGH = 1'b1
    } t_cfg_idx;

    localparam logic [7:0] DEAD_RESET    = 8'd10;
    localparam logic [7:0] ID_DIGITAL    = 8'h41;
    localparam logic [7:0] ID_ANALOG     = 8'h73;
    localparam logic [7:0] TX_FIRST      = 8'h01;
    localparam logic [7:0] TX_POLL       = 8'h42;
    localparam logic [7:0] AXIS_CENTER   = 8'h7F;
    localparam logic [7:0] AXIS_NONE     = 8'h80;
    localparam logic [7:0] HAT_NEUTRAL   = 8'h88;
    localparam logic [7:0] COMBO_LIMIT   = 8'd200;
    localparam logic [7:0] COMBO_LATCHED = 8'd222;
    localparam logic [7:0] DIR_MASK      = 8'hF0;
    localparam int         FRAME_DEPTH   = 6;

    // Byte positions within one poll; 0 means no poll is running.
    localparam logic [3:0] IDX_IDLE      = 4'd0;
    localparam logic [3:0] IDX_FIRST     = 4'd1;
    localparam logic [3:0] IDX_ID        = 4'd2;
    localparam logic [3:0] IDX_SKIP      = 4'd3;
    localparam logic [3:0] IDX_BIG       = 4'd4;
    localparam logic [3:0] IDX_LAST      = 4'd9;

    // One finished report.
    typedef struct packed {
        logic [7:0] hat_value;
        logic [7:0] right_x;
        logic [7:0] right_y;
        logic [7:0] left_x;
        logic [7:0] left_y;
        logic [7:0] buttons_first;
        logic [7:0] buttons_second;
    } t_report;

    localparam t_report REPORT_ZERO = '0;

    // Hat byte from the pressed-high first button byte.
    function automatic logic [7:0] hat_of(input logic [7:0] t1);
        logic [7:0] h;
        if (t1[4]) begin
            h = 8'h00;
        end else if (t1[6]) begin
            h = 8'hF0;
        end else begin
            h = 8'h80;
        end
        if (t1[5]) begin
            h = h + 8'h0F;
        end else if (!t1[7]) begin
            h = h + 8'h08;
        end
        return h;
    endfunction

    function automatic logic [7:0] btn_first(input logic [7:0] t1, input logic [7:0] t2);
        return {t2[5:0], t1[3], t1[0]};
    endfunction

    function automatic logic [7:0] btn_second(input logic [7:0] t1, input logic [7:0] t2);
        return {4'b0000, t1[2:1], t2[7:6]};
    endfunction

endpackage

// File: hw/rtl/game_pad_poll_and_report.sv
// ----------------------------------------------------------------------------
// Game pad poll and report
// Sequences one serial pad poll byte by byte and emits the finished report.
// ----------------------------------------------------------------------------
// Usage: each input request is either a poll start (carrying the two rumble
// motor levels) or a byte just received from the pad. A start, and each
// received byte of a running poll, produces one result: the next byte to
// send, or the finished report after the last byte (or right after an
// unsupported pad ID). A received byte while no poll runs produces nothing.
// Both channels use valid and stall. An accepted request is registered in the
// input register; its result moves on to the output register once that is
// free. While the receiver does not stall, one request is taken every cycle;
// the single input register and single output register set that rate. When
// the receiver stalls, the result holds in the output register and the input
// register fills; after that the input stall rises until the result is taken.
// Reset clears the poll state, the combo counter and both valid flags, and sets
// both dead zone edges to 10. The user must write the dead zone registers through
// the configuration port only while no request is in flight; it is not enforced.
// ----------------------------------------------------------------------------
module game_pad_poll_and_report
    import gppr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration port
    input  logic       i_cfg_we,
    input  logic       i_cfg_addr,
    input  logic [7:0] i_cfg_data,
    // Input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_operation,
    input  logic       i_small_motor,
    input  logic [7:0] i_big_motor,
    input  logic [7:0] i_rx_byte,
    // Output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_result_kind,
    output logic [7:0] o_tx_byte,
    output logic [7:0] o_hat_value,
    output logic [7:0] o_right_x,
    output logic [7:0] o_right_y,
    output logic [7:0] o_left_x,
    output logic [7:0] o_left_y,
    output logic [7:0] o_buttons_first,
    output logic [7:0] o_buttons_second
);

    // Configuration registers
    logic [7:0] r_dead_low;
    logic [7:0] r_dead_high;

    // Input register
    logic       r_s1_vld;
    logic       r_s1_op;
    logic       r_s1_small;
    logic [7:0] r_s1_big;
    logic [7:0] r_s1_rx;

    // Poll state
    logic [3:0] r_byte_index;
    logic [7:0] r_pad_kind;
    logic       r_small_motor;
    logic [7:0] r_big_motor;
    logic [7:0] r_frame [FRAME_DEPTH];
    logic [7:0] r_combo_count;

    // Output register
    logic       r_out_vld;
    logic       r_out_kind;
    logic [7:0] r_out_tx;
    t_report    r_out_rep;

    // Step logic
    logic       in_take;
    logic       s2_go;
    logic [3:0] n_byte_index;
    logic [7:0] n_pad_kind;
    logic       n_res_vld;
    t_kind      n_res_kind;
    logic [7:0] n_res_tx;
    logic       rep_build;
    logic       combo_upd;
    logic [7:0] rep_pad_kind;
    logic [7:0] rep_frame [FRAME_DEPTH];
    t_report    rep;
    logic [7:0] rep_combo;

    // Handshakes: the input register moves on when the output register is free.
    assign s2_go      = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !s2_go;
    assign in_take    = i_in_valid && !o_in_stall;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_low  <= DEAD_RESET;
            r_dead_high <= DEAD_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_DEAD_LOW:  r_dead_low  <= i_cfg_data;
                CFG_DEAD_HIGH: r_dead_high <= i_cfg_data;
                default:       r_dead_low  <= r_dead_low;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_take) begin
            r_s1_vld <= 1'b1;
        end else if (s2_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_op    <= i_operation;
            r_s1_small <= i_small_motor;
            r_s1_big   <= i_big_motor;
            r_s1_rx    <= i_rx_byte;
        end
    end

    // The report sees the last frame byte straight from the current request.
    always_comb begin
        for (int i = 0; i < FRAME_DEPTH - 1; i++) begin
            rep_frame[i] = r_frame[i];
        end
        rep_frame[FRAME_DEPTH-1] = r_s1_rx;
    end

    assign rep_pad_kind = (r_byte_index == IDX_ID) ? r_s1_rx : r_pad_kind;

    gppr_report u_report (
        .i_pad_kind    (rep_pad_kind),
        .i_frame       (rep_frame),
        .i_combo_count (r_combo_count),
        .i_dead_low    (r_dead_low),
        .i_dead_high   (r_dead_high),
        .o_report      (rep),
        .o_combo_count (rep_combo)
    );

    // Next byte, next position and result for the request in the input register.
    always_comb begin
        n_byte_index = r_byte_index;
        n_pad_kind   = r_pad_kind;
        n_res_vld    = 1'b0;
        n_res_kind   = KIND_SEND;
        n_res_tx     = 8'h00;
        rep_build    = 1'b0;
        if (t_op'(r_s1_op) == OP_START) begin
            n_byte_index = IDX_FIRST;
            n_res_vld    = 1'b1;
            n_res_tx     = TX_FIRST;
        end else if (r_byte_index == IDX_IDLE || r_byte_index > IDX_LAST) begin
            n_byte_index = IDX_IDLE;
        end else if (r_byte_index == IDX_FIRST) begin
            n_byte_index = IDX_ID;
            n_res_vld    = 1'b1;
            n_res_tx     = TX_POLL;
        end else if (r_byte_index == IDX_ID) begin
            n_pad_kind = r_s1_rx;
            n_res_vld  = 1'b1;
            if (r_s1_rx == ID_DIGITAL || r_s1_rx == ID_ANALOG) begin
                n_byte_index = IDX_SKIP;
            end else begin
                n_byte_index = IDX_IDLE;
                n_res_kind   = KIND_REPORT;
                rep_build    = 1'b1;
            end
        end else if (r_byte_index == IDX_LAST) begin
            n_byte_index = IDX_IDLE;
            n_res_vld    = 1'b1;
            n_res_kind   = KIND_REPORT;
            rep_build    = 1'b1;
        end else begin
            n_byte_index = r_byte_index + 4'd1;
            n_res_vld    = 1'b1;
            if (r_pad_kind == ID_ANALOG && r_byte_index == IDX_SKIP) begin
                n_res_tx = {7'd0, r_small_motor};
            end else if (r_pad_kind == ID_ANALOG && r_byte_index == IDX_BIG) begin
                n_res_tx = r_big_motor;
            end
        end
    end

    assign combo_upd = s2_go && rep_build;

    // Poll state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index  <= IDX_IDLE;
            r_pad_kind    <= 8'h00;
            r_small_motor <= 1'b0;
            r_big_motor   <= 8'h00;
            r_combo_count <= 8'h00;
        end else if (s2_go) begin
            r_byte_index <= n_byte_index;
            r_pad_kind   <= n_pad_kind;
            if (t_op'(r_s1_op) == OP_START) begin
                r_small_motor <= r_s1_small;
                r_big_motor   <= r_s1_big;
            end
            if (combo_upd) begin
                r_combo_count <= rep_combo;
            end
        end
    end

    // Frame bytes: the byte received for position k lands in entry k - 4.
    always_ff @(posedge i_clk) begin
        if (s2_go && t_op'(r_s1_op) == OP_RX) begin
            for (int i = 0; i < FRAME_DEPTH; i++) begin
                if (r_byte_index == IDX_BIG + 4'(i)) begin
                    r_frame[i] <= r_s1_rx;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_go) begin
            r_out_vld <= n_res_vld;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && n_res_vld) begin
            r_out_kind <= n_res_kind;
            r_out_tx   <= n_res_tx;
            r_out_rep  <= rep_build ? rep : REPORT_ZERO;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_result_kind    = r_out_kind;
    assign o_tx_byte        = r_out_tx;
    assign o_hat_value      = r_out_rep.hat_value;
    assign o_right_x        = r_out_rep.right_x;
    assign o_right_y        = r_out_rep.right_y;
    assign o_left_x         = r_out_rep.left_x;
    assign o_left_y         = r_out_rep.left_y;
    assign o_buttons_first  = r_out_rep.buttons_first;
    assign o_buttons_second = r_out_rep.buttons_second;

endmodule

// File: hw/rtl/gppr_report.sv
// ----------------------------------------------------------------------------
// Game pad report builder
// Turns the received frame bytes of one poll into a report: hat, dead-zoned
// axes, remapped buttons, and the dance mode combo counter update.
// ----------------------------------------------------------------------------
module gppr_report
    import gppr_pkg::*;
(
    input  logic [7:0] i_pad_kind,
    input  logic [7:0] i_frame [FRAME_DEPTH],
    input  logic [7:0] i_combo_count,
    input  logic [7:0] i_dead_low,
    input  logic [7:0] i_dead_high,
    output t_report    o_report,
    output logic [7:0] o_combo_count
);

    logic [7:0] t1;
    logic [7:0] t2;
    logic       combo_latched;
    logic       combo_held;
    logic [7:0] combo_base;

    // Axis dead zone: values strictly inside the window read as center.
    function automatic logic [7:0] dz(input logic [7:0] v, input logic [7:0] lo,
                                      input logic [7:0] hi);
        return (v > lo && v < hi) ? AXIS_CENTER : v;
    endfunction

    // Buttons arrive active low.
    assign t1 = ~i_frame[0];
    assign t2 = ~i_frame[1];

    // Dance mode combo tracking.
    assign combo_latched = (i_combo_count >= COMBO_LIMIT);
    assign combo_held    = t1[0] & t1[3] & t1[4];
    assign combo_base    = combo_latched ? COMBO_LATCHED : i_combo_count;

    // Report fields by pad type.
    always_comb begin
        o_report      = REPORT_ZERO;
        o_combo_count = i_combo_count;
        if (i_pad_kind == ID_DIGITAL) begin
            o_report.hat_value      = combo_latched ? HAT_NEUTRAL : hat_of(t1);
            o_report.right_x        = AXIS_NONE;
            o_report.right_y        = AXIS_NONE;
            o_report.left_x         = AXIS_NONE;
            o_report.left_y         = AXIS_NONE;
            o_report.buttons_first  = btn_first(t1, t2);
            o_report.buttons_second = btn_second(t1, t2)
                                    | (combo_latched ? (t1 & DIR_MASK) : 8'h00);
            o_combo_count           = combo_base + {7'd0, combo_held};
        end else if (i_pad_kind == ID_ANALOG) begin
            o_report.hat_value      = hat_of(t1);
            o_report.right_x        = dz(i_frame[2], i_dead_low, i_dead_high);
            o_report.right_y        = dz(i_frame[3], i_dead_low, i_dead_high);
            o_report.left_x         = dz(i_frame[4], i_dead_low, i_dead_high);
            o_report.left_y         = dz(i_frame[5], i_dead_low, i_dead_high);
            o_report.buttons_first  = btn_first(t1, t2);
            o_report.buttons_second = btn_second(t1, t2);
        end else begin
            o_report.hat_value      = HAT_NEUTRAL;
            o_report.right_x        = AXIS_NONE;
            o_report.right_y        = AXIS_NONE;
            o_report.left_x         = AXIS_NONE;
            o_report.left_y         = AXIS_NONE;
        end
    end

endmodule

// File: tb/game_pad_poll_and_report_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Game pad poll and report testbench
// Drives whole and broken pad polls through the request channel and checks
// every result against an in-bench model of the poll sequence, the report
// builder and the combo latch. Both channels idle in random bursts, and the
// receiver holds off once for a long stretch. The dead zone is moved between
// phases through the configuration port.
// ----------------------------------------------------------------------------
module game_pad_poll_and_report_tb;
    import gppr_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    // One request on the input channel.
    typedef struct packed {
        t_op        op;
        logic       small_motor;
        logic [7:0] big_motor;
        logic [7:0] rx_byte;
    } t_pad_req;

    // One result on the output channel.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] tx;
        t_report    rpt;
    } t_pad_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_addr = 1'b0;
    logic [7:0] i_cfg_data = 8'd0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic       i_operation = 1'b0;
    logic       i_small_motor = 1'b0;
    logic [7:0] i_big_motor = 8'd0;
    logic [7:0] i_rx_byte = 8'd0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_result_kind;
    logic [7:0] o_tx_byte;
    logic [7:0] o_hat_value;
    logic [7:0] o_right_x;
    logic [7:0] o_right_y;
    logic [7:0] o_left_x;
    logic [7:0] o_left_y;
    logic [7:0] o_buttons_first;
    logic [7:0] o_buttons_second;

    // Requests waiting to be sent and results still due from the block.
    t_pad_req    pad_req_q[$];
    t_pad_result due_results[$];
    t_pad_req    cur_req;

    // Model copy of the block state and its dead zone registers.
    logic [3:0] m_index = IDX_IDLE;
    logic [7:0] m_pad = 8'd0;
    logic       m_small = 1'b0;
    logic [7:0] m_big = 8'd0;
    logic [7:0] m_frame[FRAME_DEPTH];
    logic [7:0] m_combo = 8'd0;
    logic [7:0] m_dead_low = DEAD_RESET;
    logic [7:0] m_dead_high = DEAD_RESET;

    int  errors = 0;
    int  cycles = 0;
    int  results_seen = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  idle_on = 1'b1;

    game_pad_poll_and_report u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_small_motor    (i_small_motor),
        .i_big_motor      (i_big_motor),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_kind    (o_result_kind),
        .o_tx_byte        (o_tx_byte),
        .o_hat_value      (o_hat_value),
        .o_right_x        (o_right_x),
        .o_right_y        (o_right_y),
        .o_left_x         (o_left_x),
        .o_left_y         (o_left_y),
        .o_buttons_first  (o_buttons_first),
        .o_buttons_second (o_buttons_second)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hat byte: vertical nibble from up and down, horizontal from right and left.
    function automatic logic [7:0] hat_from(input logic [7:0] t1);
        logic [7:0] vert;
        vert = t1[4] ? 8'h00 : (t1[6] ? 8'hF0 : 8'h80);
        if (t1[5]) begin
            return vert + 8'h0F;
        end
        return t1[7] ? vert : vert + 8'h08;
    endfunction

    function automatic logic [7:0] first_buttons(input logic [7:0] t1, input logic [7:0] t2);
        return (t1 & 8'h01) | ((t1 & 8'h08) >> 2) | ((t2 & 8'h3F) << 2);
    endfunction

    function automatic logic [7:0] second_buttons(input logic [7:0] t1, input logic [7:0] t2);
        return ((t2 & 8'hC0) >> 6) | ((t1 & 8'h06) << 1);
    endfunction

    function automatic logic [7:0] dead_zone(input logic [7:0] v);
        return (v > m_dead_low && v < m_dead_high) ? AXIS_CENTER : v;
    endfunction

    // Build the finished report from the frame bytes; updates the combo latch.
    task automatic make_report(output t_pad_result res);
        logic [7:0] t1;
        logic [7:0] t2;
        logic [7:0] b2;
        res = '0;
        res.kind = KIND_REPORT;
        t1 = ~m_frame[0];
        t2 = ~m_frame[1];
        res.rpt.right_x = AXIS_NONE;
        res.rpt.right_y = AXIS_NONE;
        res.rpt.left_x = AXIS_NONE;
        res.rpt.left_y = AXIS_NONE;
        res.rpt.hat_value = HAT_NEUTRAL;
        if (m_pad == ID_DIGITAL) begin
            b2 = second_buttons(t1, t2);
            if (m_combo < COMBO_LIMIT) begin
                res.rpt.hat_value = hat_from(t1);
            end else begin
                // Dance mode: directions move into the second button byte.
                b2 = b2 | (t1 & DIR_MASK);
                m_combo = COMBO_LATCHED;
            end
            if (t1[0] && t1[3] && t1[4]) begin
                m_combo = m_combo + 8'd1;
            end
            res.rpt.buttons_first = first_buttons(t1, t2);
            res.rpt.buttons_second = b2;
        end else if (m_pad == ID_ANALOG) begin
            res.rpt.hat_value = hat_from(t1);
            res.rpt.right_x = dead_zone(m_frame[2]);
            res.rpt.right_y = dead_zone(m_frame[3]);
            res.rpt.left_x = dead_zone(m_frame[4]);
            res.rpt.left_y = dead_zone(m_frame[5]);
            res.rpt.buttons_first = first_buttons(t1, t2);
            res.rpt.buttons_second = second_buttons(t1, t2);
        end
    endtask

    // Step the poll model by one accepted request and queue its result.
    task automatic advance_poll(input t_pad_req r);
        logic [3:0]  k;
        t_pad_result res;
        res = '0;
        res.kind = KIND_SEND;
        k = m_index;
        if (r.op == OP_START) begin
            m_small = r.small_motor;
            m_big = r.big_motor;
            m_index = IDX_FIRST;
            res.tx = TX_FIRST;
            due_results.push_back(res);
        end else if (k == IDX_IDLE || k > IDX_LAST) begin
            // A byte with no poll running is dropped.
            m_index = IDX_IDLE;
        end else if (k == IDX_FIRST) begin
            m_index = IDX_ID;
            res.tx = TX_POLL;
            due_results.push_back(res);
        end else if (k == IDX_ID) begin
            m_pad = r.rx_byte;
            if (r.rx_byte == ID_DIGITAL || r.rx_byte == ID_ANALOG) begin
                m_index = IDX_SKIP;
            end else begin
                m_index = IDX_IDLE;
                make_report(res);
            end
            due_results.push_back(res);
        end else begin
            if (k >= IDX_BIG) begin
                m_frame[k - IDX_BIG] = r.rx_byte;
            end
            if (k == IDX_LAST) begin
                m_index = IDX_IDLE;
                make_report(res);
            end else begin
                m_index = k + 4'd1;
                if (m_pad == ID_ANALOG && k == IDX_SKIP) begin
                    res.tx = {7'd0, m_small};
                end else if (m_pad == ID_ANALOG && k == IDX_BIG) begin
                    res.tx = m_big;
                end
            end
            due_results.push_back(res);
        end
    endtask

    task automatic note_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycles, field, got, want);
        errors++;
    endtask

    // Compare one accepted result with the oldest one due.
    task automatic check_result();
        t_pad_result want;
        if (due_results.size() == 0) begin
            note_mismatch("unexpected result, tx_byte", o_tx_byte, 8'd0);
        end else begin
            want = due_results.pop_front();
            if (o_result_kind !== want.kind)
                note_mismatch("result_kind", {7'd0, o_result_kind}, {7'd0, want.kind});
            if (o_tx_byte !== want.tx)
                note_mismatch("tx_byte", o_tx_byte, want.tx);
            if (o_hat_value !== want.rpt.hat_value)
                note_mismatch("hat_value", o_hat_value, want.rpt.hat_value);
            if (o_right_x !== want.rpt.right_x)
                note_mismatch("right_x", o_right_x, want.rpt.right_x);
            if (o_right_y !== want.rpt.right_y)
                note_mismatch("right_y", o_right_y, want.rpt.right_y);
            if (o_left_x !== want.rpt.left_x)
                note_mismatch("left_x", o_left_x, want.rpt.left_x);
            if (o_left_y !== want.rpt.left_y)
                note_mismatch("left_y", o_left_y, want.rpt.left_y);
            if (o_buttons_first !== want.rpt.buttons_first)
                note_mismatch("buttons_first", o_buttons_first, want.rpt.buttons_first);
            if (o_buttons_second !== want.rpt.buttons_second)
                note_mismatch("buttons_second", o_buttons_second, want.rpt.buttons_second);
        end
    endtask

    // Request driver: takes the next pending request whenever the slot is free.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                advance_poll(cur_req);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap == 0 && idle_on && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 10);
                end
                if (send_gap > 0 && idle_on) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pad_req_q.size() > 0) begin
                    cur_req = pad_req_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_operation <= cur_req.op;
                    i_small_motor <= cur_req.small_motor;
                    i_big_motor <= cur_req.big_motor;
                    i_rx_byte <= cur_req.rx_byte;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall; one long hold-off after 100 results,
    // started while plenty of requests are still queued.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                check_result();
            end
            if (!hold_done && results_seen >= 100 && pad_req_q.size() > 10) begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 10);
                end
                if (stall_left > 0 && idle_on) begin
                    stall_left--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("game_pad_poll_and_report test failed");
            $finish;
        end
    end

    task automatic push_req(input t_op op, input logic sm, input logic [7:0] bm,
                            input logic [7:0] rx);
        t_pad_req r;
        r.op = op;
        r.small_motor = sm;
        r.big_motor = bm;
        r.rx_byte = rx;
        pad_req_q.push_back(r);
    endtask

    task automatic queue_rx(input logic [7:0] rx);
        push_req(OP_RX, 1'($urandom), 8'($urandom), rx);
    endtask

    // One poll: a start, then up to nine received bytes (fewer cuts it short).
    task automatic queue_frame(input logic sm, input logic [7:0] bm, input logic [7:0] id,
                               input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] a0, input logic [7:0] a1,
                               input logic [7:0] a2, input logic [7:0] a3,
                               input int n_bytes);
        logic [7:0] seq[9];
        int         n;
        seq = '{8'($urandom), id, 8'($urandom), b0, b1, a0, a1, a2, a3};
        n = n_bytes;
        if (id != ID_DIGITAL && id != ID_ANALOG && n > 2) begin
            n = 2;
        end
        push_req(OP_START, sm, bm, 8'($urandom));
        for (int i = 0; i < n; i++) begin
            queue_rx(seq[i]);
        end
    endtask

    // Axis values lean toward the dead zone edges.
    function automatic logic [7:0] pick_axis();
        case ($urandom_range(0, 7))
            0: return m_dead_low;
            1: return m_dead_low + 8'd1;
            2: return m_dead_high - 8'd1;
            3: return m_dead_high;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_id();
        case ($urandom_range(0, 8))
            0, 1, 2, 3: return ID_DIGITAL;
            4, 5, 6, 7: return ID_ANALOG;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly whole polls with random content, some cut short, some stray bytes.
    task automatic queue_random_poll(input bit combo);
        logic [7:0] b0;
        int         n;
        b0 = 8'($urandom);
        if (combo || $urandom_range(0, 7) == 0) begin
            b0 = b0 & ~8'h19;
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : 9;
        queue_frame(1'($urandom), 8'($urandom), combo ? ID_DIGITAL : pick_id(), b0,
                    8'($urandom), pick_axis(), pick_axis(), pick_axis(), pick_axis(), n);
        if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(1, 3)) queue_rx(8'($urandom));
        end
    endtask

    task automatic write_dead_zone(input logic [7:0] lo, input logic [7:0] hi);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_DEAD_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_addr <= CFG_DEAD_HIGH;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        m_dead_low = lo;
        m_dead_high = hi;
        @(negedge i_clk);
    endtask

    // Wait until everything sent has been answered, then let stray bytes drain.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pad_req_q.size() != 0 || i_in_valid || due_results.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    // Stimulus sequence.
    initial begin
        logic [7:0] lo_set[5];
        logic [7:0] hi_set[5];
        lo_set = '{8'd0, 8'd255, 8'd100, 8'd10, 8'd0};
        hi_set = '{8'd255, 8'd0, 8'd156, 8'd10, 8'd0};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: stray byte, analog and digital extremes, bad ID, abandoned poll.
        queue_rx(8'hA5);
        queue_frame(1'b1, 8'hFF, ID_ANALOG, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h0A, 8'h0B, 9);
        queue_frame(1'b0, 8'h00, ID_DIGITAL, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 9);
        queue_frame(1'b1, 8'h80, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 9);
        queue_frame(1'b0, 8'h00, ID_ANALOG, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 2);

        // Random polls under several dead zone settings.
        for (int s = 0; s < 5; s++) begin
            wait_idle();
            if (s == 4) begin
                lo_set[s] = 8'($urandom);
                hi_set[s] = 8'($urandom_range(lo_set[s], 255));
            end
            write_dead_zone(lo_set[s], hi_set[s]);
            repeat (8) queue_random_poll(1'b0);
        end

        // Hold the combo on a digital pad to step the combo counter.
        wait_idle();
        write_dead_zone(8'($urandom_range(0, 127)), 8'($urandom_range(128, 255)));
        for (int i = 0; i < 30; i++) begin
            queue_random_poll(i % 9 != 8);
        end

        // Last part: no idling on either side.
        wait_idle();
        write_dead_zone(8'd40, 8'd200);
        idle_on = 1'b0;
        repeat (8) queue_random_poll(1'b0);
        wait_idle();

        if (errors == 0) begin
            $display("game_pad_poll_and_report test passed");
        end else begin
            $display("game_pad_poll_and_report test failed");
        end
        $finish;
    end

endmodule

// File: game_pad_poll_and_report.f
hw/rtl/gppr_pkg.sv
hw/rtl/gppr_report.sv
hw/rtl/game_pad_poll_and_report.sv
tb/game_pad_poll_and_report_tb.sv
